@@ design/wheel_base_position_p_controller_core_defines.svh @@
// Assertion macros used by the wheel base controller RTL
`ifndef WHEEL_BASE_POSITION_P_CONTROLLER_CORE_DEFINES_SVH
`define WHEEL_BASE_POSITION_P_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define WBPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define WBPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/wbpc_pkg.sv @@
// Shared types, constants and the sine table for the wheel base controller
package wbpc_pkg;

  // fixed field and datapath widths
  localparam int unsigned DIV_N_W = 42;  // dividend: low 42 bits of a 27 x 16 bit product
  localparam int unsigned DIV_D_W = 27;  // divisor: velocity magnitude
  localparam int unsigned CNT_W   = $clog2(DIV_N_W);
  localparam int unsigned TRIG_W  = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // divide by 10000 as a shift by 4 and a reciprocal multiply for 625
  localparam int unsigned POW2_SH = 4;   // 10000 = 16 * 625
  localparam int unsigned RN_W    = 37;  // dividend after the shift
  localparam int unsigned RQ_W    = 28;  // quotient
  localparam int unsigned R_LO_W  = 19;  // low slice of the split multiply
  localparam int unsigned RECIP_W = 28;
  localparam int          DIV_ODD = 625;
  localparam logic [RECIP_W-1:0] RECIP_625 = 28'd219902325;  // floor(2^37 / 625)

  // arithmetic constants
  localparam int SCALE        = 10000;
  localparam int HALF_TURN    = 1800;
  localparam int FULL_TURN    = 3600;
  localparam int QUARTER_TURN = 900;
  localparam int NEAR_LIMIT   = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XY_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_XY_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DISABLED = 2'd0;
  localparam logic [1:0] ST_AT_GOAL  = 2'd1;
  localparam logic [1:0] ST_DRIVING  = 2'd2;

  // divide operations run by the two dividers, in issue order
  typedef enum logic [3:0] {
    OP_VX, OP_VY, OP_VW, OP_SX, OP_SY, OP_RXC, OP_RYS, OP_RYC, OP_RXS
  } div_op_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    diff;
    logic    rom_cos;
    logic    sin_take;
    logic    trig_take;
    logic    div_start;
    div_op_t op;
    logic    commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enable;
    logic near;
    logic need_scale;
    logic div_done;
  } dp_stat_t;

  // round(10000*sin) for 0 to 90.0 degrees in tenths
  typedef logic [TRIG_W-1:0] trig_rom_t [0:QUARTER_TURN];

  function automatic trig_rom_t build_sin_rom();
    trig_rom_t t;
    real       ang;
    for (int i = 0; i <= QUARTER_TURN; i++) begin
      ang  = i * 3.14159265358979323846 / 1800.0;
      t[i] = TRIG_W'($rtoi(10000.0 * $sin(ang) + 0.5));
    end
    return t;
  endfunction

  localparam trig_rom_t SIN_ROM = build_sin_rom();

endpackage

@@ design/wheel_base_position_p_controller_core.sv @@
// A disabled or at-goal item skips the trig lookup and the divides.
// Driving item: setup states plus 7 divides by 10000 on the reciprocal
// unit; two serial divides are added when x/y need scaling.
// One item at a time; the next input transfer is taken once the result is registered
// and the controller is back in idle; a result waits while the receiver is not ready.
// Reset (rst, synchronous): configuration, goal history, counters and held errors clear.
module wheel_base_position_p_controller_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [wbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            loop_enable,
  input  logic signed [23:0]              goal_x,
  input  logic signed [23:0]              goal_y,
  input  logic [11:0]                     goal_angle,
  input  logic signed [23:0]              pose_x,
  input  logic signed [23:0]              pose_y,
  input  logic [11:0]                     pose_angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      step_status,
  output logic signed [16:0]              drive_x,
  output logic signed [16:0]              drive_y,
  output logic signed [15:0]              drive_turn,
  output logic signed [24:0]              error_x,
  output logic signed [24:0]              error_y,
  output logic signed [11:0]              error_turn,
  output logic                            goal_moved,
  output logic [7:0]                      goal_move_count
);
  import wbpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wbpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  wbpc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .loop_enable     (loop_enable),
    .goal_x          (goal_x),
    .goal_y          (goal_y),
    .goal_angle      (goal_angle),
    .pose_x          (pose_x),
    .pose_y          (pose_y),
    .pose_angle      (pose_angle),
    .cmd             (cmd),
    .stat            (stat),
    .step_status     (step_status),
    .drive_x         (drive_x),
    .drive_y         (drive_y),
    .drive_turn      (drive_turn),
    .error_x         (error_x),
    .error_y         (error_y),
    .error_turn      (error_turn),
    .goal_moved      (goal_moved),
    .goal_move_count (goal_move_count)
  );

endmodule

@@ design/wbpc_div.sv @@
// Dividers: restoring unsigned divider and a reciprocal divide by 10000
module wbpc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wbpc_pkg::DIV_N_W-1:0] dividend,
  input  logic [wbpc_pkg::DIV_D_W-1:0] divisor,
  output logic                         done,
  output logic [wbpc_pkg::DIV_N_W-1:0] quotient
);
  import wbpc_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_N_W-1:0] quo;
  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W:0]   trial;
  logic               fits;
  logic [DIV_D_W-1:0] rem_next;

  // one trial subtract per step
  always_comb begin
    shifted  = {rem, quo[DIV_N_W-1]};
    trial    = shifted - {1'b0, divisor};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_N_W - 1);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_N_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// Divide by 10000: shift out 4 bits (divide by 16), then multiply by the reciprocal of 625.
// Dividend below 2^41; done is registered together with the corrected quotient.
module wbpc_rdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wbpc_pkg::DIV_N_W-1:0] dividend,
  output logic                         done,
  output logic [wbpc_pkg::RQ_W-1:0]    quotient
);
  import wbpc_pkg::*;

  logic [3:0]                     stage;
  logic [RN_W-1:0]                n;
  logic [R_LO_W+RECIP_W-1:0]      p_lo;
  logic [RN_W-R_LO_W+RECIP_W-1:0] p_hi;
  logic [R_LO_W+RECIP_W-1:0]      q_sum;
  logic [RQ_W-1:0]                q0;
  logic [RN_W-1:0]                q0_x;
  logic [RN_W-1:0]                rem;

  // estimate is low by at most one; the remainder check fixes it
  always_comb begin
    q_sum = (R_LO_W+RECIP_W)'(p_hi) +
            (R_LO_W+RECIP_W)'(p_lo[R_LO_W+RECIP_W-1:R_LO_W]);
    rem   = n - q0_x;
  end

  // stage tracker
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[2:0], start};
      done  <= stage[3];
    end
  end

  // split multiply, estimate, back-multiply, correct
  always_ff @(posedge clk) begin
    if (start) begin
      n <= dividend[RN_W+POW2_SH-1:POW2_SH];
    end
    if (stage[0]) begin
      p_lo <= (R_LO_W+RECIP_W)'(n[R_LO_W-1:0]) * (R_LO_W+RECIP_W)'(RECIP_625);
      p_hi <= (RN_W-R_LO_W+RECIP_W)'(n[RN_W-1:R_LO_W]) *
              (RN_W-R_LO_W+RECIP_W)'(RECIP_625);
    end
    if (stage[1]) begin
      q0 <= q_sum[RN_W-R_LO_W+RQ_W-1:RN_W-R_LO_W];
    end
    if (stage[2]) begin
      q0_x <= RN_W'(q0) * RN_W'(DIV_ODD);
    end
    if (stage[3]) begin
      quotient <= (rem >= RN_W'(DIV_ODD)) ? q0 + 1'b1 : q0;
    end
  end

endmodule

@@ design/wbpc_dp.sv @@
// Datapath: config registers, pose errors, trig lookup, dividers and state
module wbpc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [wbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            loop_enable,
  input  logic signed [23:0]              goal_x,
  input  logic signed [23:0]              goal_y,
  input  logic [11:0]                     goal_angle,
  input  logic signed [23:0]              pose_x,
  input  logic signed [23:0]              pose_y,
  input  logic [11:0]                     pose_angle,
  input  wbpc_pkg::dp_cmd_t               cmd,
  output wbpc_pkg::dp_stat_t              stat,
  output logic [1:0]                      step_status,
  output logic signed [16:0]              drive_x,
  output logic signed [16:0]              drive_y,
  output logic signed [15:0]              drive_turn,
  output logic signed [24:0]              error_x,
  output logic signed [24:0]              error_y,
  output logic signed [11:0]              error_turn,
  output logic                            goal_moved,
  output logic [7:0]                      goal_move_count
);
  import wbpc_pkg::*;

  // configuration
  logic [15:0] xy_gain, turn_gain;
  logic [14:0] xy_lim, turn_lim;

  // latched item
  logic               en_r;
  logic signed [23:0] gx_r, gy_r, px_r, py_r;
  logic [11:0]        ga_r, pa_r;

  // errors and trig
  logic signed [24:0] ex_r, ey_r;
  logic signed [11:0] ew_r;
  logic               near_r;
  logic [1:0]         quad_r;
  logic [9:0]         ang_r;
  logic [TRIG_W-1:0]  rom_q, sin_v;
  logic signed [14:0] c_r, s_r;

  // velocities
  logic signed [27:0] vx_r, vy_r;
  logic signed [15:0] vxs_r, vys_r, vw_r;
  logic signed [16:0] rxc_r, rys_r, ryc_r, rxs_r;
  logic               neg_r;

  // persistent state
  logic signed [23:0] last_gx, last_gy, seen_gx, seen_gy;
  logic [11:0]        last_ga, seen_ga;
  logic               moved_flag;
  logic [7:0]         move_counter;
  logic signed [24:0] held_ex, held_ey;
  logic signed [11:0] held_ew;

  // error and angle reduction
  logic signed [12:0] ew_raw, ew_wrap;
  logic               near;
  logic [11:0]        ang_mod;
  logic [1:0]         quad;
  logic [9:0]         ang_rem;

  always_comb begin
    ew_raw = $signed({1'b0, ga_r}) - $signed({1'b0, pa_r});
    if (ew_raw > HALF_TURN) begin
      ew_wrap = 13'(ew_raw - FULL_TURN);
    end else if (ew_raw < -HALF_TURN) begin
      ew_wrap = 13'(ew_raw + FULL_TURN);
    end else begin
      ew_wrap = ew_raw;
    end
    near = (ex_r > -NEAR_LIMIT) && (ex_r < NEAR_LIMIT) &&
           (ey_r > -NEAR_LIMIT) && (ey_r < NEAR_LIMIT) &&
           (ew_raw > -NEAR_LIMIT) && (ew_raw < NEAR_LIMIT);
    ang_mod = (pa_r >= 12'(FULL_TURN)) ? 12'(pa_r - 12'(FULL_TURN)) : pa_r;
    if (ang_mod >= 12'(3 * QUARTER_TURN)) begin
      quad    = 2'd3;
      ang_rem = 10'(ang_mod - 12'(3 * QUARTER_TURN));
    end else if (ang_mod >= 12'(2 * QUARTER_TURN)) begin
      quad    = 2'd2;
      ang_rem = 10'(ang_mod - 12'(2 * QUARTER_TURN));
    end else if (ang_mod >= 12'(QUARTER_TURN)) begin
      quad    = 2'd1;
      ang_rem = 10'(ang_mod - 12'(QUARTER_TURN));
    end else begin
      quad    = 2'd0;
      ang_rem = ang_mod[9:0];
    end
  end

  // magnitudes
  logic [24:0] ex_mag, ey_mag;
  logic [11:0] ew_mag;
  logic [26:0] ax, ay, amax;
  logic [15:0] vxs_mag, vys_mag;
  logic [14:0] c_mag, s_mag;

  always_comb begin
    ex_mag  = ex_r[24] ? 25'(-ex_r) : 25'(ex_r);
    ey_mag  = ey_r[24] ? 25'(-ey_r) : 25'(ey_r);
    ew_mag  = ew_r[11] ? 12'(-ew_r) : 12'(ew_r);
    ax      = vx_r[27] ? 27'(-vx_r) : 27'(vx_r);
    ay      = vy_r[27] ? 27'(-vy_r) : 27'(vy_r);
    amax    = (ax >= ay) ? ax : ay;
    vxs_mag = vxs_r[15] ? 16'(-vxs_r) : 16'(vxs_r);
    vys_mag = vys_r[15] ? 16'(-vys_r) : 16'(vys_r);
    c_mag   = c_r[14] ? 15'(-c_r) : 15'(c_r);
    s_mag   = s_r[14] ? 15'(-s_r) : 15'(s_r);
  end

  // divider operand select; only the x/y scaling has a variable divisor
  logic [26:0]        mul_a;
  logic [15:0]        mul_b;
  logic [DIV_D_W-1:0] den;
  logic               neg;
  logic               use_serial;
  logic [42:0]        prod;

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    den        = amax;
    neg        = 1'b0;
    use_serial = (cmd.op == OP_SX) || (cmd.op == OP_SY);
    case (cmd.op)
      OP_VX:  begin mul_a = 27'(ex_mag); mul_b = xy_gain;   neg = ex_r[24]; end
      OP_VY:  begin mul_a = 27'(ey_mag); mul_b = xy_gain;   neg = ey_r[24]; end
      OP_VW:  begin mul_a = 27'(ew_mag); mul_b = turn_gain; neg = ew_r[11]; end
      OP_SX:  begin mul_a = ax; mul_b = 16'(xy_lim); neg = vx_r[27]; end
      OP_SY:  begin mul_a = ay; mul_b = 16'(xy_lim); neg = vy_r[27]; end
      OP_RXC: begin
        mul_a = 27'(vxs_mag); mul_b = 16'(c_mag); neg = vxs_r[15] ^ c_r[14];
      end
      OP_RYS: begin
        mul_a = 27'(vys_mag); mul_b = 16'(s_mag); neg = vys_r[15] ^ s_r[14];
      end
      OP_RYC: begin
        mul_a = 27'(vys_mag); mul_b = 16'(c_mag); neg = vys_r[15] ^ c_r[14];
      end
      OP_RXS: begin
        mul_a = 27'(vxs_mag); mul_b = 16'(s_mag); neg = vxs_r[15] ^ s_r[14];
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  logic               sdiv_done, rdiv_done, div_done;
  logic [DIV_N_W-1:0] quotient;
  logic [RQ_W-1:0]    rquot;
  logic [27:0]        q_mag;
  logic signed [28:0] qs;

  wbpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start && use_serial),
    .dividend (prod[DIV_N_W-1:0]),
    .divisor  (den),
    .done     (sdiv_done),
    .quotient (quotient)
  );

  wbpc_rdiv u_rdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start && !use_serial),
    .dividend (prod[DIV_N_W-1:0]),
    .done     (rdiv_done),
    .quotient (rquot)
  );

  assign div_done = sdiv_done || rdiv_done;
  assign q_mag    = use_serial ? quotient[27:0] : rquot;
  assign qs       = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // status to controller
  always_comb begin
    stat.enable     = en_r;
    stat.near       = near_r;
    stat.need_scale = (ax > 27'(xy_lim)) || (ay > 27'(xy_lim));
    stat.div_done   = div_done;
  end

  // final commands
  logic signed [15:0] tlim, dw;
  logic               moved;
  logic [10:0]        rom_addr;

  always_comb begin
    tlim = $signed({1'b0, turn_lim});
    if (vw_r > tlim) begin
      dw = tlim;
    end else if (vw_r < -tlim) begin
      dw = -tlim;
    end else begin
      dw = vw_r;
    end
    moved    = !((last_gx == gx_r) && (last_gy == gy_r) && (last_ga == ga_r));
    rom_addr = cmd.rom_cos ? 11'(QUARTER_TURN - int'(ang_r)) : 11'(ang_r);
  end

  // sine table, registered read
  always_ff @(posedge clk) begin
    rom_q <= SIN_ROM[rom_addr[9:0]];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      xy_gain   <= '0;
      turn_gain <= '0;
      xy_lim    <= '0;
      turn_lim  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_XY_GAIN:    xy_gain   <= cfg_data;
        CFG_TURN_GAIN:  turn_gain <= cfg_data;
        CFG_XY_LIMIT:   xy_lim    <= cfg_data[14:0];
        CFG_TURN_LIMIT: turn_lim  <= cfg_data[14:0];
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      en_r <= loop_enable;
      gx_r <= goal_x;
      gy_r <= goal_y;
      ga_r <= goal_angle;
      px_r <= pose_x;
      py_r <= pose_y;
      pa_r <= pose_angle;
    end
    if (cmd.diff) begin
      ex_r   <= $signed({gx_r[23], gx_r}) - $signed({px_r[23], px_r});
      ey_r   <= $signed({gy_r[23], gy_r}) - $signed({py_r[23], py_r});
      quad_r <= quad;
      ang_r  <= ang_rem;
    end
    // ex/ey settle in the diff state, before the wrap state registers near and the wrapped turn error
    if (cmd.diff || cmd.sin_take) begin
      ew_r <= ew_wrap[11:0];
    end
    near_r <= near;
    if (cmd.sin_take) begin
      sin_v <= rom_q;
    end
    if (cmd.trig_take) begin
      unique case (quad_r)
        2'd0: begin c_r <= $signed({1'b0, rom_q});  s_r <= $signed({1'b0, sin_v});  end
        2'd1: begin c_r <= -$signed({1'b0, sin_v}); s_r <= $signed({1'b0, rom_q});  end
        2'd2: begin c_r <= -$signed({1'b0, rom_q}); s_r <= -$signed({1'b0, sin_v}); end
        2'd3: begin c_r <= $signed({1'b0, sin_v});  s_r <= -$signed({1'b0, rom_q}); end
      endcase
    end
    if (cmd.div_start) begin
      neg_r <= neg;
    end
    // quotient capture for the operation in flight
    if (div_done) begin
      case (cmd.op)
        OP_VX:  begin vx_r <= 28'(qs); vxs_r <= 16'(qs); end
        OP_VY:  begin vy_r <= 28'(qs); vys_r <= 16'(qs); end
        OP_VW:  vw_r  <= 16'(qs);
        OP_SX:  vxs_r <= 16'(qs);
        OP_SY:  vys_r <= 16'(qs);
        OP_RXC: rxc_r <= 17'(qs);
        OP_RYS: rys_r <= 17'(qs);
        OP_RYC: ryc_r <= 17'(qs);
        OP_RXS: rxs_r <= 17'(qs);
        default: ;
      endcase
    end
  end

  // persistent state, updated as the result is handed off
  always_ff @(posedge clk) begin
    if (rst) begin
      last_gx      <= '0;
      last_gy      <= '0;
      last_ga      <= '0;
      seen_gx      <= '0;
      seen_gy      <= '0;
      seen_ga      <= '0;
      moved_flag   <= 1'b0;
      move_counter <= '0;
      held_ex      <= '0;
      held_ey      <= '0;
      held_ew      <= '0;
    end else if (cmd.commit) begin
      if (!en_r) begin
        last_gx <= seen_gx;
        last_gy <= seen_gy;
        last_ga <= seen_ga;
      end else begin
        seen_gx <= gx_r;
        seen_gy <= gy_r;
        seen_ga <= ga_r;
        if (!near_r) begin
          last_gx    <= gx_r;
          last_gy    <= gy_r;
          last_ga    <= ga_r;
          moved_flag <= moved;
          if (moved) begin
            move_counter <= move_counter + 1'b1;
          end
          held_ex <= ex_r;
          held_ey <= ey_r;
          held_ew <= ew_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (en_r && !near_r) begin
        step_status     <= ST_DRIVING;
        drive_x         <= rxc_r - rys_r;
        drive_y         <= ryc_r + rxs_r;
        drive_turn      <= dw;
        error_x         <= ex_r;
        error_y         <= ey_r;
        error_turn      <= ew_r;
        goal_moved      <= moved;
        goal_move_count <= moved ? move_counter + 1'b1 : move_counter;
      end else begin
        step_status     <= en_r ? ST_AT_GOAL : ST_DISABLED;
        drive_x         <= '0;
        drive_y         <= '0;
        drive_turn      <= '0;
        error_x         <= held_ex;
        error_y         <= held_ey;
        error_turn      <= held_ew;
        goal_moved      <= moved_flag;
        goal_move_count <= move_counter;
      end
    end
  end

endmodule

@@ design/wbpc_ctrl.sv @@
// Controller: sequences one item through the datapath and owns the handshakes
`include "wheel_base_position_p_controller_core_defines.svh"
module wbpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output wbpc_pkg::dp_cmd_t  cmd,
  input  wbpc_pkg::dp_stat_t stat
);
  import wbpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_WRAP, S_DECIDE, S_SIN, S_COS, S_TRIG, S_GO, S_WAIT, S_DONE
  } state_t;

  state_t  state;
  div_op_t op;
  logic    accept;
  logic    commit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  // datapath commands
  always_comb begin
    cmd.load      = accept;
    cmd.diff      = (state == S_DIFF);
    cmd.rom_cos   = (state == S_COS);
    cmd.sin_take  = (state == S_COS) || (state == S_WRAP);
    cmd.trig_take = (state == S_TRIG);
    cmd.div_start = (state == S_GO);
    cmd.op        = op;
    cmd.commit    = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_VX;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (accept) state <= S_DIFF;
        S_DIFF:   state <= S_WRAP;
        S_WRAP:   state <= S_DECIDE;
        S_DECIDE: begin
          op <= OP_VX;
          state <= (!stat.enable || stat.near) ? S_DONE : S_SIN;
        end
        S_SIN:    state <= S_COS;
        S_COS:    state <= S_TRIG;
        S_TRIG:   state <= S_GO;
        S_GO:     state <= S_WAIT;
        S_WAIT: begin
          if (stat.div_done) begin
            state <= S_GO;
            unique case (op)
              OP_VX:  op <= OP_VY;
              OP_VY:  op <= OP_VW;
              OP_VW:  op <= stat.need_scale ? OP_SX : OP_RXC;
              OP_SX:  op <= OP_SY;
              OP_SY:  op <= OP_RXC;
              OP_RXC: op <= OP_RYS;
              OP_RYS: op <= OP_RYC;
              OP_RYC: op <= OP_RXS;
              OP_RXS: state <= S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_DONE:   if (commit) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  `WBPC_ASSERT_IMP(a_done_in_wait, stat.div_done, state == S_WAIT, "divider done outside wait")
  `WBPC_ASSERT_NXT(a_accept_busy, accept, !in_ready, "second item taken while busy")
  `WBPC_ASSERT_IMP(a_rise_from_done, $rose(out_valid), $past(state == S_DONE),
                   "result shown without finishing an item")

endmodule
